FILE: src/thefsm_pkg.sv
// Package for the threshold hysteresis event state machine.
// Holds the level and event codes, register indexes, reset values and shared structs.
// No dependencies.
package thefsm_pkg;

    localparam int unsigned CFG_AW = 5;

    typedef enum logic [2:0] {
        LVL_LNR    = 3'd0,
        LVL_LCRIT  = 3'd1,
        LVL_LOW    = 3'd2,
        LVL_NORMAL = 3'd3,
        LVL_HIGH   = 3'd4,
        LVL_HCRIT  = 3'd5,
        LVL_UNR    = 3'd6
    } t_level;

    typedef enum logic [3:0] {
        EVT_LNR_UP   = 4'd0,
        EVT_LNR_DOWN = 4'd1,
        EVT_LC_UP    = 4'd2,
        EVT_LC_DOWN  = 4'd3,
        EVT_LNC_UP   = 4'd4,
        EVT_LNC_DOWN = 4'd5,
        EVT_UNC_UP   = 4'd6,
        EVT_UNC_DOWN = 4'd7,
        EVT_UC_UP    = 4'd8,
        EVT_UC_DOWN  = 4'd9,
        EVT_UNR_UP   = 4'd10,
        EVT_UNR_DOWN = 4'd11
    } t_event;

    typedef enum logic [2:0] {
        REG_UNR    = 3'd0,
        REG_UC     = 3'd1,
        REG_UNC    = 3'd2,
        REG_LNR    = 3'd3,
        REG_LC     = 3'd4,
        REG_LNC    = 3'd5,
        REG_HYST_F = 3'd6,
        REG_HYST_R = 3'd7
    } t_reg_idx;

    localparam logic [7:0] RST_UNR    = 8'd85;
    localparam logic [7:0] RST_UC     = 8'd80;
    localparam logic [7:0] RST_UNC    = 8'd75;
    localparam logic [7:0] RST_LNR    = 8'hEC;
    localparam logic [7:0] RST_LC     = 8'hF6;
    localparam logic [7:0] RST_LNC    = 8'h00;
    localparam logic [7:0] RST_HYST_F = 8'd2;
    localparam logic [7:0] RST_HYST_R = 8'd2;

    typedef struct packed {
        logic signed [7:0] unr;
        logic signed [7:0] uc;
        logic signed [7:0] unc;
        logic signed [7:0] lnr;
        logic signed [7:0] lc;
        logic signed [7:0] lnc;
        logic [7:0]        hyst_f;
        logic [7:0]        hyst_r;
    } t_cfg;

    typedef struct packed {
        t_level level;
        logic   first_event_valid;
        t_event first_event;
        logic   second_event_valid;
        t_event second_event;
    } t_step_res;

endpackage

FILE: src/thefsm_in_if.sv
// Input channel: one sensor reading per beat.
// Standalone, no dependencies.
interface thefsm_in_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] reading;

    modport source (output valid, output reading, input ready);
    modport sink   (input valid, input reading, output ready);
endinterface

FILE: src/thefsm_out_if.sv
// Output channel: level and up to two threshold events per beat.
// Standalone, no dependencies.
interface thefsm_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] level;
    logic       first_event_valid;
    logic [3:0] first_event;
    logic       second_event_valid;
    logic [3:0] second_event;

    modport source (output valid, output level, output first_event_valid, output first_event,
                    output second_event_valid, output second_event, input ready);
    modport sink   (input valid, input level, input first_event_valid, input first_event,
                    input second_event_valid, input second_event, output ready);
endinterface

FILE: src/thefsm_regs.sv
// APB configuration register file: six thresholds and two hysteresis values.
// Depends on thefsm_pkg.
module thefsm_regs
    import thefsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    t_reg_idx   w_idx;
    logic [7:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unr    <= RST_UNR;
            r_cfg.uc     <= RST_UC;
            r_cfg.unc    <= RST_UNC;
            r_cfg.lnr    <= RST_LNR;
            r_cfg.lc     <= RST_LC;
            r_cfg.lnc    <= RST_LNC;
            r_cfg.hyst_f <= RST_HYST_F;
            r_cfg.hyst_r <= RST_HYST_R;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_UNR:    r_cfg.unr    <= pwdata[7:0];
                REG_UC:     r_cfg.uc     <= pwdata[7:0];
                REG_UNC:    r_cfg.unc    <= pwdata[7:0];
                REG_LNR:    r_cfg.lnr    <= pwdata[7:0];
                REG_LC:     r_cfg.lc     <= pwdata[7:0];
                REG_LNC:    r_cfg.lnc    <= pwdata[7:0];
                REG_HYST_F: r_cfg.hyst_f <= pwdata[7:0];
                REG_HYST_R: r_cfg.hyst_r <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_UNR:    w_rd = r_cfg.unr;
            REG_UC:     w_rd = r_cfg.uc;
            REG_UNC:    w_rd = r_cfg.unc;
            REG_LNR:    w_rd = r_cfg.lnr;
            REG_LC:     w_rd = r_cfg.lc;
            REG_LNC:    w_rd = r_cfg.lnc;
            REG_HYST_F: w_rd = r_cfg.hyst_f;
            REG_HYST_R: w_rd = r_cfg.hyst_r;
            default:    w_rd = 8'd0;
        endcase
    end

    assign prdata = {24'd0, w_rd};
    assign o_cfg  = r_cfg;

endmodule

FILE: src/thefsm_step.sv
// Level transition logic: threshold compares, next level and event codes for one reading.
// Depends on thefsm_pkg.
module thefsm_step
    import thefsm_pkg::*;
(
    input  t_level            i_level,
    input  logic signed [7:0] i_reading,
    input  t_cfg              i_cfg,
    output t_step_res         o_res
);

    logic signed [9:0] w_v;
    logic signed [9:0] w_unr, w_uc, w_unc, w_lnr, w_lc, w_lnc;
    logic signed [9:0] w_hf, w_hr;
    logic              w_chk_a, w_chk_b;
    t_level            w_lvl_a, w_lvl_b;
    t_event            w_evt_a, w_evt_b;

    assign w_v   = {{2{i_reading[7]}}, i_reading};
    assign w_unr = {{2{i_cfg.unr[7]}}, i_cfg.unr};
    assign w_uc  = {{2{i_cfg.uc[7]}}, i_cfg.uc};
    assign w_unc = {{2{i_cfg.unc[7]}}, i_cfg.unc};
    assign w_lnr = {{2{i_cfg.lnr[7]}}, i_cfg.lnr};
    assign w_lc  = {{2{i_cfg.lc[7]}}, i_cfg.lc};
    assign w_lnc = {{2{i_cfg.lnc[7]}}, i_cfg.lnc};
    assign w_hf  = {2'b00, i_cfg.hyst_f};
    assign w_hr  = {2'b00, i_cfg.hyst_r};

    // a: first check of the level, b: second check (wins when both fire)
    always_comb begin
        w_chk_a = 1'b0;
        w_chk_b = 1'b0;
        w_lvl_a = i_level;
        w_lvl_b = i_level;
        w_evt_a = EVT_LNR_UP;
        w_evt_b = EVT_LNR_UP;
        unique case (i_level)
            LVL_LNR: begin
                w_chk_a = (w_v >= w_lnr + w_hr);
                w_lvl_a = LVL_LCRIT;
                w_evt_a = EVT_LNR_UP;
            end
            LVL_LCRIT: begin
                w_chk_a = (w_v <= w_lnr);
                w_lvl_a = LVL_LNR;
                w_evt_a = EVT_LNR_DOWN;
                w_chk_b = (w_v > w_lc + w_hr);
                w_lvl_b = LVL_LOW;
                w_evt_b = EVT_LC_UP;
            end
            LVL_LOW: begin
                w_chk_a = (w_v <= w_lc);
                w_lvl_a = LVL_LCRIT;
                w_evt_a = EVT_LC_DOWN;
                w_chk_b = (w_v > w_lnc + w_hr);
                w_lvl_b = LVL_NORMAL;
                w_evt_b = EVT_LNC_UP;
            end
            LVL_NORMAL: begin
                w_chk_a = (w_v <= w_lnc);
                w_lvl_a = LVL_LOW;
                w_evt_a = EVT_LNC_DOWN;
                w_chk_b = (w_v >= w_unc);
                w_lvl_b = LVL_HIGH;
                w_evt_b = EVT_UNC_UP;
            end
            LVL_HIGH: begin
                w_chk_a = (w_v >= w_uc);
                w_lvl_a = LVL_HCRIT;
                w_evt_a = EVT_UC_UP;
                w_chk_b = (w_v < w_unc - w_hf);
                w_lvl_b = LVL_NORMAL;
                w_evt_b = EVT_UNC_DOWN;
            end
            LVL_HCRIT: begin
                w_chk_a = (w_v >= w_unr);
                w_lvl_a = LVL_UNR;
                w_evt_a = EVT_UNR_UP;
                w_chk_b = (w_v < w_uc - w_hf);
                w_lvl_b = LVL_HIGH;
                w_evt_b = EVT_UC_DOWN;
            end
            LVL_UNR: begin
                w_chk_a = (w_v < w_unr - w_hf);
                w_lvl_a = LVL_HCRIT;
                w_evt_a = EVT_UNR_DOWN;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (w_chk_b) begin
            o_res.level = w_lvl_b;
        end else if (w_chk_a) begin
            o_res.level = w_lvl_a;
        end else begin
            o_res.level = i_level;
        end
        o_res.first_event_valid  = w_chk_a | w_chk_b;
        o_res.second_event_valid = w_chk_a & w_chk_b;
        if (w_chk_a) begin
            o_res.first_event = w_evt_a;
        end else if (w_chk_b) begin
            o_res.first_event = w_evt_b;
        end else begin
            o_res.first_event = EVT_LNR_UP;
        end
        o_res.second_event = (w_chk_a & w_chk_b) ? w_evt_b : EVT_LNR_UP;
    end

endmodule

FILE: src/threshold_hysteresis_event_fsm_core.sv
// Threshold hysteresis event state machine, top level.
// An accepted reading passes the input register, then the result register, to reach its result beat.
// Throughput: one reading per cycle unless the result output stalls; the level register updates as a result is loaded.
// Reset (synchronous, active low): pipeline empty, level normal, config registers to defaults.
// Depends on thefsm_pkg, thefsm_in_if, thefsm_out_if, thefsm_regs, thefsm_step.
module threshold_hysteresis_event_fsm_core
    import thefsm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    thefsm_in_if.sink         i_sample,
    thefsm_out_if.source      o_result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg              w_cfg;
    t_step_res         w_res;
    logic              r_in_valid;
    logic signed [7:0] r_reading;
    logic              r_out_valid;
    t_step_res         r_out;
    t_level            r_level;
    logic              w_out_load;
    logic              w_in_take;

    thefsm_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    thefsm_step u_step (
        .i_level   (r_level),
        .i_reading (r_reading),
        .i_cfg     (w_cfg),
        .o_res     (w_res)
    );

    assign w_out_load     = r_in_valid & (~r_out_valid | o_result.ready);
    assign w_in_take      = i_sample.valid & i_sample.ready;
    assign i_sample.ready = ~r_in_valid | w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= LVL_NORMAL;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_out_load) begin
                r_in_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_level     <= w_res.level;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_reading <= i_sample.reading;
        end
        if (w_out_load) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.level              = r_out.level;
    assign o_result.first_event_valid  = r_out.first_event_valid;
    assign o_result.first_event        = r_out.first_event;
    assign o_result.second_event_valid = r_out.second_event_valid;
    assign o_result.second_event       = r_out.second_event;

endmodule

FILE: src/thefsm_chk.sv
// Port-level checker for the threshold event core, attached by bind.
// Depends on threshold_hysteresis_event_fsm_core ports only.
module thefsm_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic [2:0] i_level,
    input logic       i_fev,
    input logic [3:0] i_fe,
    input logic       i_sev,
    input logic [3:0] i_se
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_level) && $stable(i_fe))
        else $error("result beat dropped or changed while stalled");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_level != 3'd7)
        else $error("unreachable level code on result");

    a_second_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_sev |-> i_fev && i_se != i_fe)
        else $error("second event without a distinct first event");

    a_quiet_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_fev |-> i_fe == 4'd0 && !i_sev && i_se == 4'd0)
        else $error("event code set without an event");

endmodule

bind threshold_hysteresis_event_fsm_core thefsm_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_level (o_result.level),
    .i_fev   (o_result.first_event_valid),
    .i_fe    (o_result.first_event),
    .i_sev   (o_result.second_event_valid),
    .i_se    (o_result.second_event)
);
